@@ rtl/core/amrb_pkg.sv @@
// Package of the audio module register bank: register map, reset values,
// command types passed from the front end to the back end. No dependencies.
package amrb_pkg;

  // Configuration defaults.
  localparam int unsigned LedCountDefault   = 3;
  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned MaxDataBytes      = 9;

  // Register map.
  localparam logic [7:0] AddrMic       = 8'h00;
  localparam logic [7:0] AddrMode      = 8'h10;
  localparam logic [7:0] AddrPresent   = 8'h20;
  localparam logic [7:0] AddrBright    = 8'h30;
  localparam logic [7:0] AddrColourLo  = 8'h40;
  localparam logic [7:0] AddrColourHi  = 8'h48;
  localparam logic [7:0] AddrSave      = 8'hF0;
  localparam logic [7:0] AddrUpgrade   = 8'hFD;
  localparam logic [7:0] AddrVersion   = 8'hFE;
  localparam logic [7:0] AddrSlave     = 8'hFF;

  // Value limits and reset values.
  localparam logic [7:0] BrightMax     = 8'd100;
  localparam logic [6:0] BrightReset   = 7'd10;
  localparam logic [7:0] SlaveMin      = 8'h08;
  localparam logic [7:0] SlaveMax      = 8'h77;
  localparam logic [6:0] SlaveReset    = 7'h33;
  localparam logic [7:0] FwVersion     = 8'd1;

  // Input operation codes.
  localparam logic [1:0] OpBus         = 2'd0;
  localparam logic [1:0] OpPinRise     = 2'd1;
  localparam logic [1:0] OpPinLow      = 2'd2;

  // Command classes produced by the front end.
  typedef enum logic [3:0] {
    CMD_PIN_SET,
    CMD_PIN_CLR,
    CMD_RD_REG,
    CMD_RD_BURST,
    CMD_WR_MIC,
    CMD_WR_MODE,
    CMD_WR_BRIGHT,
    CMD_WR_COLOUR,
    CMD_WR_SLAVE,
    CMD_WR_UPGRADE,
    CMD_WR_SAVE,
    CMD_WR_REJECT
  } cmd_op_e;

  // Single-register read selection.
  typedef enum logic [2:0] {
    RD_MIC,
    RD_MODE,
    RD_PRESENT,
    RD_BRIGHT,
    RD_VERSION,
    RD_SLAVE
  } rd_sel_e;

  // One classified command as held in the queue.
  typedef struct packed {
    cmd_op_e         op;
    rd_sel_e         rd_sel;
    logic [3:0]      start;
    logic [3:0]      count;
    logic [8:0][7:0] data;
  } cmd_t;

  // One result item with the current pin levels.
  typedef struct packed {
    logic       kind;
    logic [7:0] rdata;
    logic       last;
    logic       mic;
    logic       mode;
    logic       led_upd;
    logic       save_req;
    logic       rst_req;
    logic       addr_chg;
    logic [6:0] slave;
  } res_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_BURST
  } back_state_e;

endpackage

@@ rtl/core/audio_module_register_bank_core.sv @@
// Audio module register bank, top level. A transaction enters the command queue at its
// accepting edge; the back end then pops it and loads its result into the output register.
// Throughput: one transaction per cycle while results are taken; a colour burst read
// holds the back end while it returns its bytes (up to nine) while a two-entry command queue
// lets new transactions in. Reset is asynchronous, active low, and restores all settings.
// Depends on amrb_pkg, amrb_front, amrb_queue and amrb_back.
module audio_module_register_bank_core #(
  parameter int unsigned LedCount   = amrb_pkg::LedCountDefault,
  parameter int unsigned QueueDepth = amrb_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] reg_addr_i,
  input  logic [3:0] byte_count_i,
  input  logic [7:0] data0_i,
  input  logic [7:0] data1_i,
  input  logic [7:0] data2_i,
  input  logic [7:0] data3_i,
  input  logic [7:0] data4_i,
  input  logic [7:0] data5_i,
  input  logic [7:0] data6_i,
  input  logic [7:0] data7_i,
  input  logic [7:0] data8_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       result_kind_o,
  output logic [7:0] read_data_o,
  output logic       last_byte_o,
  output logic       mic_enable_pin_o,
  output logic       hp_mode_pin_o,
  output logic       led_update_o,
  output logic       save_request_o,
  output logic       reset_request_o,
  output logic       address_changed_o,
  output logic [6:0] slave_address_o
);
  import amrb_pkg::*;

  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  cmd_t            push_cmd;
  cmd_t            pop_cmd;
  res_t            res;
  logic [8:0][7:0] data;

  assign data = {data8_i, data7_i, data6_i, data5_i, data4_i,
                 data3_i, data2_i, data1_i, data0_i};

  amrb_front #(
    .LedCount (LedCount)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .reg_addr_i   (reg_addr_i),
    .byte_count_i (byte_count_i),
    .data_i       (data),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  amrb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .pop_cmd_o  (pop_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  amrb_back #(
    .LedCount (LedCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Unpack the result transaction onto the output ports.
  assign result_kind_o     = res.kind;
  assign read_data_o       = res.rdata;
  assign last_byte_o       = res.last;
  assign mic_enable_pin_o  = res.mic;
  assign hp_mode_pin_o     = res.mode;
  assign led_update_o      = res.led_upd;
  assign save_request_o    = res.save_req;
  assign reset_request_o   = res.rst_req;
  assign address_changed_o = res.addr_chg;
  assign slave_address_o   = res.slave;

endmodule

@@ rtl/core/amrb_front.sv @@
// Front end of the register bank: classifies each bus transaction or pin event
// into a command and pushes the ones it keeps into the queue. Depends on amrb_pkg.
module amrb_front #(
  parameter int unsigned LedCount = amrb_pkg::LedCountDefault
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       reg_addr_i,
  input  logic [3:0]       byte_count_i,
  input  logic [8:0][7:0]  data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output amrb_pkg::cmd_t   q_cmd_o
);
  import amrb_pkg::*;

  localparam int unsigned ColourBytes = LedCount * 3;

  logic       keep;
  logic       one;
  logic [7:0] offset;
  logic       in_colour;

  assign one       = (byte_count_i == 4'd1);
  assign offset    = reg_addr_i - AddrColourLo;
  assign in_colour = (reg_addr_i >= AddrColourLo) && (reg_addr_i <= AddrColourHi);

  // Decode the transaction; items that cause nothing are dropped here.
  always_comb begin
    keep            = 1'b1;
    q_cmd_o.op      = CMD_WR_REJECT;
    q_cmd_o.rd_sel  = RD_MIC;
    q_cmd_o.start   = offset[3:0];
    q_cmd_o.count   = byte_count_i;
    q_cmd_o.data    = data_i;
    case (operation_i)
      OpPinRise: q_cmd_o.op = CMD_PIN_SET;
      OpPinLow:  q_cmd_o.op = CMD_PIN_CLR;
      OpBus: begin
        if (byte_count_i == 4'd0) begin
          q_cmd_o.op = CMD_RD_REG;
          if (in_colour) begin
            q_cmd_o.op = CMD_RD_BURST;
            if (offset >= 8'(ColourBytes)) keep = 1'b0;
          end else begin
            case (reg_addr_i)
              AddrMic:     q_cmd_o.rd_sel = RD_MIC;
              AddrMode:    q_cmd_o.rd_sel = RD_MODE;
              AddrPresent: q_cmd_o.rd_sel = RD_PRESENT;
              AddrBright:  q_cmd_o.rd_sel = RD_BRIGHT;
              AddrVersion: q_cmd_o.rd_sel = RD_VERSION;
              AddrSlave:   q_cmd_o.rd_sel = RD_SLAVE;
              default:     keep = 1'b0;
            endcase
          end
        end else if (in_colour) begin
          if (byte_count_i <= 4'(MaxDataBytes)) q_cmd_o.op = CMD_WR_COLOUR;
        end else if (one) begin
          case (reg_addr_i)
            AddrMic:     q_cmd_o.op = CMD_WR_MIC;
            AddrMode:    q_cmd_o.op = CMD_WR_MODE;
            AddrBright:  q_cmd_o.op = CMD_WR_BRIGHT;
            AddrSlave:   q_cmd_o.op = CMD_WR_SLAVE;
            AddrUpgrade: q_cmd_o.op = CMD_WR_UPGRADE;
            AddrSave:    q_cmd_o.op = CMD_WR_SAVE;
            default:     q_cmd_o.op = CMD_WR_REJECT;
          endcase
        end
      end
      default: keep = 1'b0;
    endcase
  end

  // Accept whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

@@ rtl/core/amrb_queue.sv @@
// Command queue between the front end and the back end of the register bank.
// Small circular buffer of commands. Depends on amrb_pkg.
module amrb_queue #(
  parameter int unsigned Depth = amrb_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  amrb_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output amrb_pkg::cmd_t pop_cmd_o,
  output logic           full_o,
  output logic           empty_o
);
  import amrb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

@@ rtl/core/amrb_back.sv @@
// Back end of the register bank: holds the settings, carries out queued
// commands and drives the output register. Depends on amrb_pkg.
module amrb_back #(
  parameter int unsigned LedCount = amrb_pkg::LedCountDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  amrb_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output amrb_pkg::res_t res_o
);
  import amrb_pkg::*;

  localparam int unsigned ColourBytes = LedCount * 3;
  localparam int unsigned IdxW        = (ColourBytes > 1) ? $clog2(ColourBytes) : 1;

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            mic_q, mic_d;
  logic            mode_q, mode_d;
  logic            present_q, present_d;
  logic [6:0]      bright_q, bright_d;
  logic [6:0]      slave_q, slave_d;
  logic            smic_q, smic_d;
  logic            smode_q, smode_d;
  logic [6:0]      sbright_q, sbright_d;
  logic [7:0]      colour_q [ColourBytes];
  logic [7:0]      colour_d [ColourBytes];

  logic            out_valid_q, out_valid_d;
  logic            kind_q, kind_d;
  logic [7:0]      rdata_q, rdata_d;
  logic            last_q, last_d;
  logic            led_q, led_d;
  logic            save_q, save_d;
  logic            rst_q, rst_d;
  logic            achg_q, achg_d;

  logic            can_load;
  logic [7:0]      d0;
  logic [IdxW-1:0] first_idx;
  logic [IdxW-1:0] burst_idx;
  logic            burst_last;

  assign can_load  = !out_valid_q || !out_stall_i;
  assign d0        = q_cmd_i.data[0];
  assign first_idx = IdxW'(q_cmd_i.start);
  assign burst_idx = (state_q == BK_IDLE) ? first_idx : idx_q;
  assign burst_last = ((IdxW + 1)'(burst_idx) + 1'b1) == (IdxW + 1)'(ColourBytes);

  // Command execution and output register loading.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mic_d       = mic_q;
    mode_d      = mode_q;
    present_d   = present_q;
    bright_d    = bright_q;
    slave_d     = slave_q;
    smic_d      = smic_q;
    smode_d     = smode_q;
    sbright_d   = sbright_q;
    for (int j = 0; j < ColourBytes; j++) colour_d[j] = colour_q[j];
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    rdata_d     = rdata_q;
    last_d      = last_q;
    led_d       = led_q;
    save_d      = save_q;
    rst_d       = rst_q;
    achg_d      = achg_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && can_load) begin
          q_pop_o = 1'b1;
          // Defaults for a write acknowledge.
          kind_d  = 1'b1;
          rdata_d = 8'd0;
          last_d  = 1'b1;
          led_d   = 1'b0;
          save_d  = 1'b0;
          rst_d   = 1'b0;
          achg_d  = 1'b0;
          out_valid_d = 1'b1;
          case (q_cmd_i.op)
            CMD_PIN_SET: begin
              present_d   = 1'b1;
              out_valid_d = 1'b0;
            end
            CMD_PIN_CLR: begin
              present_d   = 1'b0;
              out_valid_d = 1'b0;
            end
            CMD_RD_REG: begin
              kind_d = 1'b0;
              case (q_cmd_i.rd_sel)
                RD_MIC:     rdata_d = {7'd0, mic_q};
                RD_MODE:    rdata_d = {7'd0, mode_q};
                RD_PRESENT: rdata_d = {7'd0, present_q};
                RD_BRIGHT:  rdata_d = {1'b0, bright_q};
                RD_VERSION: rdata_d = FwVersion;
                RD_SLAVE:   rdata_d = {1'b0, slave_q};
                default:    rdata_d = 8'd0;
              endcase
            end
            CMD_RD_BURST: begin
              kind_d  = 1'b0;
              rdata_d = colour_q[burst_idx];
              last_d  = burst_last;
              if (!burst_last) begin
                idx_d   = burst_idx + 1'b1;
                state_d = BK_BURST;
              end
            end
            CMD_WR_MIC: begin
              if (d0 <= 8'd1) mic_d = d0[0];
            end
            CMD_WR_MODE: begin
              if (d0 <= 8'd1) mode_d = d0[0];
            end
            CMD_WR_BRIGHT: begin
              if (d0 <= BrightMax && d0[6:0] != bright_q) begin
                bright_d = d0[6:0];
                led_d    = 1'b1;
              end
            end
            CMD_WR_COLOUR: begin
              // Each colour byte takes the data byte that lands on it.
              for (int j = 0; j < ColourBytes; j++) begin
                if (4'(j) >= q_cmd_i.start &&
                    (4'(j) - q_cmd_i.start) < q_cmd_i.count) begin
                  colour_d[j] = q_cmd_i.data[4'(j) - q_cmd_i.start];
                end
              end
              led_d = 1'b1;
            end
            CMD_WR_SLAVE: begin
              if (d0 >= SlaveMin && d0 <= SlaveMax && d0[6:0] != slave_q) begin
                slave_d = d0[6:0];
                achg_d  = 1'b1;
              end
            end
            CMD_WR_UPGRADE: begin
              if (d0 != 8'd0) rst_d = 1'b1;
            end
            CMD_WR_SAVE: begin
              if (d0 == 8'd1 && (mic_q != smic_q || mode_q != smode_q ||
                                 bright_q != sbright_q)) begin
                smic_d    = mic_q;
                smode_d   = mode_q;
                sbright_d = bright_q;
                save_d    = 1'b1;
              end
            end
            default: begin
              // Rejected write: plain acknowledge.
            end
          endcase
        end
      end
      BK_BURST: begin
        // Remaining bytes of a colour burst, one per cycle while results are taken.
        if (can_load) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b0;
          rdata_d     = colour_q[burst_idx];
          last_d      = burst_last;
          led_d       = 1'b0;
          save_d      = 1'b0;
          rst_d       = 1'b0;
          achg_d      = 1'b0;
          idx_d       = burst_idx + 1'b1;
          if (burst_last) state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control state and settings.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      mic_q       <= 1'b1;
      mode_q      <= 1'b0;
      present_q   <= 1'b0;
      bright_q    <= BrightReset;
      slave_q     <= SlaveReset;
      smic_q      <= 1'b1;
      smode_q     <= 1'b0;
      sbright_q   <= BrightReset;
      for (int j = 0; j < ColourBytes; j++) colour_q[j] <= 8'd0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      mic_q       <= mic_d;
      mode_q      <= mode_d;
      present_q   <= present_d;
      bright_q    <= bright_d;
      slave_q     <= slave_d;
      smic_q      <= smic_d;
      smode_q     <= smode_d;
      sbright_q   <= sbright_d;
      for (int j = 0; j < ColourBytes; j++) colour_q[j] <= colour_d[j];
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    rdata_q <= rdata_d;
    last_q  <= last_d;
    led_q   <= led_d;
    save_q  <= save_d;
    rst_q   <= rst_d;
    achg_q  <= achg_d;
  end

  // Settings do not change while a result waits, so pin levels come from state.
  assign out_valid_o    = out_valid_q;
  assign res_o.kind     = kind_q;
  assign res_o.rdata    = rdata_q;
  assign res_o.last     = last_q;
  assign res_o.mic      = mic_q;
  assign res_o.mode     = mode_q;
  assign res_o.led_upd  = led_q;
  assign res_o.save_req = save_q;
  assign res_o.rst_req  = rst_q;
  assign res_o.addr_chg = achg_q;
  assign res_o.slave    = slave_q;

endmodule
